[rtl/imt_pkg.sv]
// Shared types, register indexes, status codes and defaults for the iterative mean threshold.
`timescale 1ns / 1ps

package imt_pkg;

    localparam int BINS      = 256;
    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam int DEF_MAX_PIXELS     = 1048576;
    localparam int DEF_MAX_ITERATIONS = 64;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_GAP = 2'd1;

    localparam logic [PIX_W-1:0] RST_INIT_THR = 8'd200;
    localparam logic [PIX_W-1:0] RST_STOP_GAP = 8'd10;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NO_CONV  = 2'd2;
    localparam logic [1:0] STAT_TOO_MANY = 2'd3;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_SWEEP,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_RESULT
    } t_state;

    // Control from the sequencer to the histogram store.
    typedef struct packed {
        logic             inc;
        logic             clr;
        logic [PIX_W-1:0] addr;
    } t_hist_ctl;

endpackage

[rtl/iterative_mean_threshold.sv]
// Top level: pixel histogram and iterative mean threshold sequencer.
// Pixels are taken one word per cycle while accumulating; the histogram increment is a
// read-modify-write on the bin memory with a bypass. After the last pixel: a drain state,
// then per iteration a bin sweep (one memory read a cycle), a check, 8 divider steps and
// an evaluate state, then a result state that loads the result.
// Synchronous active-low reset clears control, counts and bin valid bits; registers
// return to 200 (initial threshold) and 10 (stop gap).
`timescale 1ns / 1ps

module iterative_mean_threshold #(
    parameter int MAX_PIXELS     = imt_pkg::DEF_MAX_PIXELS,
    parameter int MAX_ITERATIONS = imt_pkg::DEF_MAX_ITERATIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [imt_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_last_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [imt_pkg::PIX_W-1:0]     o_threshold,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [imt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [imt_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + imt_pkg::PIX_W;
    localparam int IW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
    localparam int PW = imt_pkg::PIX_W;

    imt_pkg::t_state    r_state, n_state;
    imt_pkg::t_hist_ctl w_ctl;

    logic [CW-1:0]  w_bin;
    logic [PW-1:0]  r_init_thr, r_gap;
    logic [CW-1:0]  r_total;
    logic           r_ovf;
    logic [PW-1:0]  r_cur;
    logic [1:0]     r_stat;
    logic [IW-1:0]  r_iter;
    logic [PW:0]    r_addr;
    logic           r_sw_on;
    logic [PW-1:0]  r_sw_g;
    logic [CW-1:0]  r_dn, r_bn;
    logic [SW-1:0]  r_ds, r_bs;
    logic [SW-1:0]  r_rem_d, r_rem_b, r_den_d, r_den_b;
    logic [PW-1:0]  r_qd, r_qb;
    logic [2:0]     r_dstep;
    logic           r_o_valid;
    logic [PW-1:0]  r_o_thr;
    logic [1:0]     r_o_stat;

    logic           w_in_acc;
    logic           w_full;
    logic           w_out_free;
    logic [SW-1:0]  w_prod;
    logic           w_ge_d, w_ge_b;
    logic [PW:0]    w_mean_sum;
    logic [PW-1:0]  w_nxt, w_diff;
    logic           w_stop;
    logic           w_last_iter;

    imt_hist #(
        .CW (CW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .o_rd_data (w_bin)
    );

    assign o_ready     = (r_state == imt_pkg::ST_ACCUM);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_threshold = r_o_thr;
    assign o_status    = r_o_stat;

    assign w_in_acc   = i_valid && o_ready;
    assign w_full     = (r_total >= CW'(MAX_PIXELS));
    assign w_out_free = !r_o_valid || i_ready;
    assign w_prod     = SW'(w_bin) * SW'(r_sw_g);
    assign w_ge_d     = (r_rem_d >= r_den_d);
    assign w_ge_b     = (r_rem_b >= r_den_b);
    assign w_mean_sum = {1'b0, r_qd} + {1'b0, r_qb};
    assign w_nxt      = w_mean_sum[PW:1];
    assign w_diff     = (r_cur >= w_nxt) ? (r_cur - w_nxt) : (w_nxt - r_cur);
    assign w_stop     = (w_diff < r_gap);
    assign w_last_iter = (r_iter == IW'(MAX_ITERATIONS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imt_pkg::ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_ctl.inc     = 1'b0;
        w_ctl.clr     = 1'b0;
        w_ctl.addr    = r_addr[PW-1:0];
        case (r_state)
            imt_pkg::ST_ACCUM: begin
                w_ctl.addr = i_pixel;
                w_ctl.inc  = w_in_acc && !w_full;
                if (w_in_acc && i_last_pixel) begin
                    n_state = imt_pkg::ST_DRAIN;
                end
            end
            imt_pkg::ST_DRAIN: begin
                n_state = r_ovf ? imt_pkg::ST_RESULT : imt_pkg::ST_SWEEP;
            end
            imt_pkg::ST_SWEEP: begin
                if (r_addr[PW]) begin
                    n_state = imt_pkg::ST_CHECK;
                end
            end
            imt_pkg::ST_CHECK: begin
                if (r_dn == '0 || r_bn == '0) begin
                    n_state = imt_pkg::ST_RESULT;
                end else begin
                    n_state = imt_pkg::ST_DIV;
                end
            end
            imt_pkg::ST_DIV: begin
                if (r_dstep == 3'd7) begin
                    n_state = imt_pkg::ST_EVAL;
                end
            end
            imt_pkg::ST_EVAL: begin
                if (w_stop || w_last_iter) begin
                    n_state = imt_pkg::ST_RESULT;
                end else begin
                    n_state = imt_pkg::ST_SWEEP;
                end
            end
            imt_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    w_ctl.clr = 1'b1;
                    n_state   = imt_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = imt_pkg::ST_ACCUM;
            end
        endcase
    end

    // Control and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr <= imt_pkg::RST_INIT_THR;
            r_gap      <= imt_pkg::RST_STOP_GAP;
            r_total    <= '0;
            r_ovf      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_sw_on    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == imt_pkg::REG_INIT_THR) begin
                    r_init_thr <= i_cfg_data;
                end else if (i_cfg_index == imt_pkg::REG_STOP_GAP) begin
                    r_gap <= i_cfg_data;
                end
            end
            if (w_in_acc) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_total <= r_total + CW'(1);
                end
            end
            r_sw_on <= (r_state == imt_pkg::ST_SWEEP) && !r_addr[PW];
            if (r_state == imt_pkg::ST_RESULT && w_out_free) begin
                r_o_valid <= 1'b1;
                r_total   <= '0;
                r_ovf     <= 1'b0;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Iteration datapath.
    always_ff @(posedge i_clk) begin
        r_sw_g <= r_addr[PW-1:0];
        if (r_sw_on) begin
            if (r_sw_g >= r_cur) begin
                r_bn <= r_bn + w_bin;
                r_bs <= r_bs + w_prod;
            end else begin
                r_dn <= r_dn + w_bin;
                r_ds <= r_ds + w_prod;
            end
        end
        case (r_state)
            imt_pkg::ST_DRAIN: begin
                r_cur  <= r_init_thr;
                r_stat <= imt_pkg::STAT_TOO_MANY;
                r_iter <= '0;
                r_addr <= '0;
                r_dn   <= '0;
                r_bn   <= '0;
                r_ds   <= '0;
                r_bs   <= '0;
            end
            imt_pkg::ST_SWEEP: begin
                if (!r_addr[PW]) begin
                    r_addr <= r_addr + (PW+1)'(1);
                end
            end
            imt_pkg::ST_CHECK: begin
                r_stat  <= imt_pkg::STAT_EMPTY;
                r_rem_d <= r_ds;
                r_rem_b <= r_bs;
                r_den_d <= SW'(r_dn) << (PW - 1);
                r_den_b <= SW'(r_bn) << (PW - 1);
                r_dstep <= '0;
            end
            imt_pkg::ST_DIV: begin
                // Restoring division, one quotient bit a cycle; both means fit in 8 bits.
                if (w_ge_d) begin
                    r_rem_d <= r_rem_d - r_den_d;
                end
                if (w_ge_b) begin
                    r_rem_b <= r_rem_b - r_den_b;
                end
                r_den_d <= r_den_d >> 1;
                r_den_b <= r_den_b >> 1;
                r_qd    <= {r_qd[PW-2:0], w_ge_d};
                r_qb    <= {r_qb[PW-2:0], w_ge_b};
                r_dstep <= r_dstep + 3'd1;
            end
            imt_pkg::ST_EVAL: begin
                if (w_stop) begin
                    r_stat <= imt_pkg::STAT_OK;
                end else begin
                    r_cur  <= w_nxt;
                    r_stat <= imt_pkg::STAT_NO_CONV;
                    r_iter <= r_iter + IW'(1);
                    r_addr <= '0;
                    r_dn   <= '0;
                    r_bn   <= '0;
                    r_ds   <= '0;
                    r_bs   <= '0;
                end
            end
            imt_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    r_o_thr  <= r_cur;
                    r_o_stat <= r_stat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/imt_hist.sv]
// Histogram store: registered-read memory with increment pipeline, bypass and valid bits.
`timescale 1ns / 1ps

module imt_hist #(
    parameter int CW = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imt_pkg::t_hist_ctl i_ctl,
    output logic [CW-1:0]      o_rd_data
);

    logic [CW-1:0]                mem [imt_pkg::BINS];
    logic [imt_pkg::BINS-1:0]     r_vld;
    logic [CW-1:0]                r_rd_data;
    logic                         r_rd_vld;
    logic                         r_s1_valid;
    logic [imt_pkg::PIX_W-1:0]    r_s1_addr;
    logic                         r_byp;
    logic [CW-1:0]                r_byp_data;
    logic [CW-1:0]                w_old;
    logic [CW-1:0]                n_cnt;

    // A bin that has not been written since the last clear reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    // The increment in flight is written in the cycle after its read, so a read of
    // the same bin in that cycle takes the new count from the bypass register.
    assign w_old = r_byp ? r_byp_data : o_rd_data;
    assign n_cnt = w_old + CW'(1);

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_ctl.addr];
        r_rd_vld  <= r_vld[i_ctl.addr];
        r_s1_addr <= i_ctl.addr;
        r_byp_data <= n_cnt;
        if (r_s1_valid) begin
            mem[r_s1_addr] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.inc;
            r_byp      <= i_ctl.inc && r_s1_valid && (r_s1_addr == i_ctl.addr);
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (r_s1_valid) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

endmodule

[bench/tb.sv]
// Self-checking testbench for the iterative mean threshold block.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD   = 8;
    localparam int PW           = imt_pkg::PIX_W;
    localparam int XW           = imt_pkg::CFG_IDX_W;
    localparam int DW           = imt_pkg::CFG_DAT_W;
    localparam int MAX_PIX      = imt_pkg::DEF_MAX_PIXELS;
    localparam int MAX_ITER     = imt_pkg::DEF_MAX_ITERATIONS;
    // Random images stay small so that many results are checked.
    localparam int IMG_MAX_PIX  = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CFG_SETTLE   = 4;
    localparam int END_CYCLES   = 2 + 267 * 2;
    localparam int TIMEOUT_CYCLES = 100000000;

    // Indexes that map to no register.
    localparam logic [XW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [XW-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [PW-1:0] threshold;
        logic [1:0]    status;
    } t_thr_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_ready;
    logic [PW-1:0]        i_pixel      = '0;
    logic                 i_last_pixel = 1'b0;
    logic                 o_valid;
    logic                 i_ready      = 1'b0;
    logic [PW-1:0]        o_threshold;
    logic [1:0]           o_status;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [XW-1:0]        i_cfg_index  = '0;
    logic [DW-1:0]        i_cfg_data   = '0;

    iterative_mean_threshold #(
        .MAX_PIXELS     (MAX_PIX),
        .MAX_ITERATIONS (MAX_ITER)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_threshold  (o_threshold),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow copy of the block's histogram, counters and registers.
    int unsigned      bin_count [imt_pkg::BINS];
    int unsigned      pix_total;
    bit               pix_overflow;
    logic [PW-1:0]    init_thr_reg;
    logic [PW-1:0]    stop_gap_reg;

    t_thr_result pending_thresholds [$];
    int          err_count = 0;
    bit          calm      = 1'b0;
    bit          tx_active = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Class means, midpoint update and stop test over the shadow histogram.
    function automatic t_thr_result isodata_threshold();
        logic [PW-1:0]    cur;
        longint unsigned  dark_n, dark_s, bright_n, bright_s;
        int unsigned      dark_m, bright_m, nxt, diff;
        t_thr_result      r;
        cur = init_thr_reg;
        for (int it = 0; it < MAX_ITER; it++) begin
            dark_n = 0;
            dark_s = 0;
            bright_n = 0;
            bright_s = 0;
            for (int g = 0; g < imt_pkg::BINS; g++) begin
                if (g >= cur) begin
                    bright_n += bin_count[g];
                    bright_s += longint'(bin_count[g]) * g;
                end else begin
                    dark_n += bin_count[g];
                    dark_s += longint'(bin_count[g]) * g;
                end
            end
            if (dark_n == 0 || bright_n == 0) begin
                r.threshold = cur;
                r.status = imt_pkg::STAT_EMPTY;
                return r;
            end
            dark_m = int'(dark_s / dark_n);
            bright_m = int'(bright_s / bright_n);
            nxt = (dark_m + bright_m) >> 1;
            diff = (cur >= nxt) ? (cur - nxt) : (nxt - cur);
            if (diff < stop_gap_reg) begin
                r.threshold = cur;
                r.status = imt_pkg::STAT_OK;
                return r;
            end
            cur = nxt[PW-1:0];
        end
        r.threshold = cur;
        r.status = imt_pkg::STAT_NO_CONV;
        return r;
    endfunction

    task automatic stream_stop();
        if (tx_active) begin
            i_valid <= 1'b0;
        end
        tx_active = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_thresholds.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sends one pixel word and updates the shadow state when it is taken.
    task automatic send_pixel(input logic [PW-1:0] px, input logic last);
        t_thr_result r;
        if (!calm && $urandom_range(0, 99) < 7) begin
            stream_stop();
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel      <= px;
        i_last_pixel <= last;
        tx_active = 1'b1;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (pix_total >= MAX_PIX) begin
            pix_overflow = 1'b1;
        end else begin
            bin_count[px]++;
            pix_total++;
        end
        if (last) begin
            if (pix_overflow) begin
                r.threshold = init_thr_reg;
                r.status = imt_pkg::STAT_TOO_MANY;
            end else begin
                r = isodata_threshold();
            end
            pending_thresholds.push_back(r);
            foreach (bin_count[g]) bin_count[g] = 0;
            pix_total = 0;
            pix_overflow = 1'b0;
        end
    endtask

    // Register writes happen only once the block has nothing left to deliver.
    task automatic write_reg(input logic [XW-1:0] idx, input logic [DW-1:0] data);
        stream_stop();
        wait_idle();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            imt_pkg::REG_INIT_THR: init_thr_reg = data;
            imt_pkg::REG_STOP_GAP: stop_gap_reg = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_defaults();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    task automatic test_single_pixel();
        send_pixel(8'd128, 1'b1);
    endtask

    task automatic test_zero_threshold();
        write_reg(imt_pkg::REG_INIT_THR, 8'd0);
        send_pixel(8'd3, 1'b0);
        send_pixel(8'd250, 1'b1);
    endtask

    task automatic test_zero_gap();
        write_reg(imt_pkg::REG_INIT_THR, 8'd128);
        write_reg(imt_pkg::REG_STOP_GAP, 8'd0);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd240, 1'b1);
    endtask

    task automatic test_max_gap();
        write_reg(imt_pkg::REG_INIT_THR, 8'd255);
        write_reg(imt_pkg::REG_STOP_GAP, 8'd255);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    // Writes to unused indexes must leave both registers alone.
    task automatic test_unknown_index();
        write_reg(REG_SPARE_A, 8'd0);
        write_reg(REG_SPARE_B, 8'd0);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    // Random images, mostly two clusters of grey, with occasional reconfiguration.
    task automatic test_random();
        int unsigned sent;
        int          size, mode, c_lo, c_hi, spread, v, pick;
        sent = 0;
        write_reg(imt_pkg::REG_INIT_THR, imt_pkg::RST_INIT_THR);
        write_reg(imt_pkg::REG_STOP_GAP, imt_pkg::RST_STOP_GAP);
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 400 && sent < 700);
            if ($urandom_range(0, 99) < 25) begin
                pick = $urandom_range(0, 9);
                write_reg(imt_pkg::REG_INIT_THR, (pick == 0) ? 8'd0 :
                                        (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 19);
                write_reg(imt_pkg::REG_STOP_GAP, (pick == 0) ? 8'd0 :
                                        (pick == 1) ? 8'd255 :
                                        (pick < 4)  ? 8'd1 : 8'($urandom_range(1, 40)));
            end
            size = $urandom_range(1, IMG_MAX_PIX);
            mode = $urandom_range(0, 3);
            c_lo = $urandom_range(0, 127);
            c_hi = $urandom_range(128, 255);
            spread = $urandom_range(0, 24);
            for (int n = 0; n < size; n++) begin
                if (mode == 0) begin
                    v = $urandom_range(0, 255);
                end else begin
                    v = ($urandom_range(0, 1) ? c_hi : c_lo)
                        + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                send_pixel(PW'(v), n == size - 1);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin
        t_thr_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_thresholds.size() == 0) begin
                $display("%0t: unexpected result threshold %0d status %0d",
                         $time, o_threshold, o_status);
                err_count++;
            end else begin
                want = pending_thresholds.pop_front();
                if (o_threshold !== want.threshold) begin
                    $display("%0t: threshold mismatch: expected %0d, actual %0d",
                             $time, want.threshold, o_threshold);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    err_count++;
                end
            end
        end
    end

    initial begin
        foreach (bin_count[g]) bin_count[g] = 0;
        pix_total = 0;
        pix_overflow = 1'b0;
        init_thr_reg = imt_pkg::RST_INIT_THR;
        stop_gap_reg = imt_pkg::RST_STOP_GAP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_single_pixel();
        test_zero_threshold();
        test_zero_gap();
        test_max_gap();
        test_unknown_index();
        test_random();

        stream_stop();
        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_thresholds.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
